/* design/hbd_pkg.sv */
// ----------------------------------------------------------------------------
// Hilbert block distance package
// Shared widths, quadrant codes and the unit status struct for the curve lanes,
// the square root unit and the top level.
// ----------------------------------------------------------------------------
package hbd_pkg;

   // Field widths of the request and response transactions.
   localparam int LEVEL_W     = 5;
   localparam int IDX_W       = 33;
   localparam int COORD_OUT_W = 16;
   localparam int DIST_W      = 20;

   // The squared distance saturates the result at and above this bit.
   localparam int D2_SAT_BIT  = 34;
   localparam int D2_EXT_W    = 64;

   // Ten times the distance is the root of one hundred times the square.
   localparam int SCALE_FACTOR = 100;

   // Radicand and root widths of the square root unit.
   localparam int V_W        = 42;
   localparam int ROOT_STEPS = V_W / 2;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int REM_W      = ROOT_W + 1;
   localparam int TRIAL_W    = REM_W + 2;
   localparam int STEP_CNT_W = $clog2(ROOT_STEPS + 1);

   // Quadrant of one curve level.
   typedef enum logic [1:0] {
      QUAD_SWAP = 2'd0,
      QUAD_UP   = 2'd1,
      QUAD_DIAG = 2'd2,
      QUAD_FLIP = 2'd3
   } quad_type;

   // Progress of an iterating unit as seen by the controller.
   typedef struct packed {
      logic busy;
      logic last;
   } unit_status_type;

endpackage

/* design/hilbert_block_distance_unit.sv */
// ----------------------------------------------------------------------------
// Hilbert block distance unit
// Maps two block numbers to curve coordinates in two parallel lanes and
// merges them into ten times their Euclidean distance, rounded to nearest.
// ----------------------------------------------------------------------------
// Sequence: the lanes walk one level a cycle over L, the saturated level;
// the merge then registers the differences, squares, sum and scaled radicand,
// and the bit-serial square root finishes the distance. A new request is
// taken only once the last one has left for the output register; a finished
// result waits in that register while the next request is taken.
// Reset is synchronous and active high; it empties the unit and the output.
module hilbert_block_distance_unit
   import hbd_pkg::*;
#(
   parameter int MAX_LEVEL = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic [IDX_W-1:0]       req_block_a,
   input  logic [IDX_W-1:0]       req_block_b,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_OUT_W-1:0] rsp_a_x,
   output logic [COORD_OUT_W-1:0] rsp_a_y,
   output logic [COORD_OUT_W-1:0] rsp_b_x,
   output logic [COORD_OUT_W-1:0] rsp_b_y,
   output logic [DIST_W-1:0]      rsp_distance
);

   localparam int COORD_W = MAX_LEVEL;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int D2_W    = SQ_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_WALK  = 8'b0000_0010,
      ST_DIFF  = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_SUM   = 8'b0001_0000,
      ST_SCALE = 8'b0010_0000,
      ST_ROOT  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic                   accept;
   logic [LEVEL_W-1:0]     level_sat;
   unit_status_type        lane_a_status, lane_b_status, root_status;
   logic [COORD_W-1:0]     ax, ay, bx, by;
   logic [ROOT_W-1:0]      root;
   logic [REM_W-1:0]       rem;

   logic [COORD_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]        dx2_ff, dy2_ff;
   logic [D2_W-1:0]        d2_ff;
   logic                   sat_ff, sat_in;
   logic [D2_EXT_W-1:0]    d2_ext;
   logic [V_W-1:0]         v_scaled;
   logic [ROOT_W:0]        dist_full;
   logic [DIST_W-1:0]      dist_rnd;
   logic                   out_load;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COORD_OUT_W-1:0] a_x_ff, a_y_ff, b_x_ff, b_y_ff;
   logic [DIST_W-1:0]      distance_ff;

   // A new transaction enters only while the datapath is empty.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign level_sat = (req_level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : req_level;

   // One curve lane for each block number.
   hbd_lane #(
      .COORD_W (COORD_W)
   ) u_lane_a (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .level  (level_sat),
      .idx    (req_block_a - IDX_W'(1)),
      .status (lane_a_status),
      .x      (ax),
      .y      (ay)
   );

   hbd_lane #(
      .COORD_W (COORD_W)
   ) u_lane_b (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .level  (level_sat),
      .idx    (req_block_b - IDX_W'(1)),
      .status (lane_b_status),
      .x      (bx),
      .y      (by)
   );

   // Merge: absolute differences, squares, their sum and the scaled radicand.
   always_comb begin
      dx_in    = (ax > bx) ? (ax - bx) : (bx - ax);
      dy_in    = (ay > by) ? (ay - by) : (by - ay);
      d2_ext   = D2_EXT_W'(d2_ff);
      sat_in   = |d2_ext[D2_EXT_W-1:D2_SAT_BIT];
      v_scaled = V_W'(V_W'(d2_ext[D2_SAT_BIT-1:0]) * V_W'(SCALE_FACTOR));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (state_ff == ST_MUL) begin
         dx2_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
         dy2_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      end
      if (state_ff == ST_SUM) begin
         d2_ff <= D2_W'(dx2_ff) + D2_W'(dy2_ff);
      end
      if (state_ff == ST_SCALE) begin
         sat_ff <= sat_in;
      end
   end

   hbd_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (state_ff == ST_SCALE),
      .v      (v_scaled),
      .status (root_status),
      .root   (root),
      .rem    (rem)
   );

   // Round to nearest: step up when the remainder exceeds the root.
   always_comb begin
      dist_full = (ROOT_W + 1)'(root) + (ROOT_W + 1)'(rem > REM_W'(root));
      if (sat_ff || (dist_full > (ROOT_W + 1)'({DIST_W{1'b1}}))) begin
         dist_rnd = '1;
      end else begin
         dist_rnd = DIST_W'(dist_full);
      end
   end

   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_WALK;
         ST_WALK:  if (lane_a_status.last) state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ROOT;
         ST_ROOT:  if (root_status.last) state_in = ST_DONE;
         ST_DONE:  if (out_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Output register holds a finished transaction until it is taken.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         a_x_ff      <= COORD_OUT_W'(ax);
         a_y_ff      <= COORD_OUT_W'(ay);
         b_x_ff      <= COORD_OUT_W'(bx);
         b_y_ff      <= COORD_OUT_W'(by);
         distance_ff <= dist_rnd;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_a_x      = a_x_ff;
   assign rsp_a_y      = a_y_ff;
   assign rsp_b_x      = b_x_ff;
   assign rsp_b_y      = b_y_ff;
   assign rsp_distance = distance_ff;

`ifndef SYNTHESIS
   // Both lanes start together and walk the same number of levels.
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lane_a_status == lane_b_status)
      else $error("Curve lanes out of step.");

   // An accepted transaction starts the level walk.
   a_accept_walks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WALK))
      else $error("Accepted transaction did not start the walk.");

   // The root unit is iterating for as long as the sequencer waits on it.
   a_root_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> root_status.busy)
      else $error("Waiting on an idle root unit.");

   // A response appears only after the final stage.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("Response raised outside the final stage.");
`endif

endmodule

/* design/hbd_lane.sv */
// ----------------------------------------------------------------------------
// Hilbert block distance curve lane
// Walks one block index up the curve levels, one level per cycle, and
// holds the grid coordinates that the walk reaches.
// ----------------------------------------------------------------------------
module hbd_lane
   import hbd_pkg::*;
#(
   parameter int COORD_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [LEVEL_W-1:0]   level,
   input  logic [IDX_W-1:0]     idx,
   output unit_status_type      status,
   output logic [COORD_W-1:0]   x,
   output logic [COORD_W-1:0]   y
);

   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [COORD_W-1:0] m_ff, m_in;
   logic [IDX_W-1:0]   rest_ff, rest_in;
   logic [LEVEL_W-1:0] cnt_ff, cnt_in;

   logic [COORD_W-1:0] two_s_m1;
   logic [COORD_W-1:0] half_s;
   quad_type           quad;

   // The mask m is S-1; since x and y stay below S, subtractions from
   // S-1 and 2S-1 are plain inversions and additions of S are ORs.
   always_comb begin
      two_s_m1 = (m_ff << 1) | COORD_W'(1);
      half_s   = two_s_m1 & ~m_ff;
      quad     = quad_type'(rest_ff[1:0]);
      // At the top level every higher index bit folds into the last quadrant.
      if ((cnt_ff == LEVEL_W'(1)) && (|rest_ff[IDX_W-1:2])) begin
         quad = QUAD_FLIP;
      end
   end

   // Next coordinates for one curve level.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      rest_in = rest_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         x_in    = '0;
         y_in    = '0;
         m_in    = '0;
         rest_in = idx;
         cnt_in  = level;
      end else if (cnt_ff != '0) begin
         unique case (quad)
            QUAD_SWAP: begin
               x_in = y_ff;
               y_in = x_ff;
            end
            QUAD_UP: begin
               y_in = y_ff | half_s;
            end
            QUAD_DIAG: begin
               x_in = x_ff | half_s;
               y_in = y_ff | half_s;
            end
            QUAD_FLIP: begin
               x_in = two_s_m1 ^ y_ff;
               y_in = m_ff ^ x_ff;
            end
            default: begin
               x_in = x_ff;
               y_in = y_ff;
            end
         endcase
         m_in    = two_s_m1;
         rest_in = rest_ff >> 2;
         cnt_in  = cnt_ff - LEVEL_W'(1);
      end
   end

   // Level counter is control state; the coordinates are payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      m_ff    <= m_in;
      rest_ff <= rest_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.last = (cnt_ff <= LEVEL_W'(1));
   assign x           = x_ff;
   assign y           = y_ff;

endmodule

/* design/hbd_isqrt.sv */
// ----------------------------------------------------------------------------
// Hilbert block distance square root unit
// Digit-by-digit restoring integer square root, one root bit per cycle,
// returning the floor root and the remainder v - root*root.
// ----------------------------------------------------------------------------
module hbd_isqrt
   import hbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [V_W-1:0]        v,
   output unit_status_type       status,
   output logic [ROOT_W-1:0]     root,
   output logic [REM_W-1:0]      rem
);

   logic [V_W-1:0]        vsh_ff, vsh_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;

   logic [TRIAL_W-1:0] part_rem;
   logic [TRIAL_W-1:0] trial;

   // Bring down the next two radicand bits and try the next root bit.
   always_comb begin
      part_rem = {rem_ff, vsh_ff[V_W-1:V_W-2]};
      trial    = TRIAL_W'({root_ff, 2'b01});
      vsh_in   = vsh_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         vsh_in  = v;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = STEP_CNT_W'(ROOT_STEPS);
      end else if (cnt_ff != '0) begin
         vsh_in = vsh_ff << 2;
         cnt_in = cnt_ff - STEP_CNT_W'(1);
         if (part_rem >= trial) begin
            rem_in  = REM_W'(part_rem - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(part_rem);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      vsh_ff  <= vsh_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.last = (cnt_ff == STEP_CNT_W'(1));
   assign root        = root_ff;
   assign rem         = rem_ff;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Hilbert block distance unit testbench
// Sends curve level and block number queries through the request channel and
// checks every response against a local model of the curve walk and of the
// rounded distance. Directed corner queries come first, then random queries,
// with random idling on both channels, one long response hold-off and one
// full drain.
// ----------------------------------------------------------------------------
module testbench;
   import hbd_pkg::*;

   localparam int CURVE_MAX_LEVEL = 16;
   localparam int RANDOM_QUERIES  = 1080;
   localparam int QUIET_TAIL      = 120;
   localparam int HOLD_AT         = 300;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_AT        = 700;
   localparam int SETTLE_CYCLES   = 60;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [IDX_W-1:0]   block_a;
      logic [IDX_W-1:0]   block_b;
   } query_type;

   typedef struct packed {
      logic [COORD_OUT_W-1:0] a_x;
      logic [COORD_OUT_W-1:0] a_y;
      logic [COORD_OUT_W-1:0] b_x;
      logic [COORD_OUT_W-1:0] b_y;
      logic [DIST_W-1:0]      distance;
   } placement_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [LEVEL_W-1:0]     req_level = '0;
   logic [IDX_W-1:0]       req_block_a = '0;
   logic [IDX_W-1:0]       req_block_b = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_OUT_W-1:0] rsp_a_x;
   logic [COORD_OUT_W-1:0] rsp_a_y;
   logic [COORD_OUT_W-1:0] rsp_b_x;
   logic [COORD_OUT_W-1:0] rsp_b_y;
   logic [DIST_W-1:0]      rsp_distance;

   query_type     pending_queries[$];
   placement_type awaited_answers[$];

   int queries_sent = 0;
   int answers_checked = 0;
   int mismatch_count = 0;
   int odd_queries = 0;
   int hold_left = 0;
   int cycle_count = 0;
   logic [DIST_W-1:0] widest_distance = '0;

   hilbert_block_distance_unit #(
      .MAX_LEVEL(CURVE_MAX_LEVEL)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_level    (req_level),
      .req_block_a  (req_block_a),
      .req_block_b  (req_block_b),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_a_x      (rsp_a_x),
      .rsp_a_y      (rsp_a_y),
      .rsp_b_x      (rsp_b_x),
      .rsp_b_y      (rsp_b_y),
      .rsp_distance (rsp_distance)
   );

   always #6 clock = ~clock;

   // Walk the curve from the lowest level up and return the grid point.
   function automatic logic [127:0] curve_point(input int unsigned levels,
                                                input logic [IDX_W-1:0] index);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] half;
      logic [63:0] digit;
      logic [63:0] nx;
      logic [63:0] ny;
      x = '0;
      y = '0;
      for (int unsigned k = 1; k <= levels; k++) begin
         half  = 64'd1 << (k - 1);
         digit = 64'(index) >> (2 * (k - 1));
         // Below the top level only one digit counts; at the top, any
         // larger value behaves as the last quadrant.
         if (k < levels) begin
            digit = digit & 64'd3;
         end else if (digit > 64'd3) begin
            digit = 64'd3;
         end
         case (quad_type'(digit[1:0]))
            QUAD_SWAP: begin
               nx = y;
               ny = x;
            end
            QUAD_UP: begin
               nx = x;
               ny = half + y;
            end
            QUAD_DIAG: begin
               nx = x + half;
               ny = half + y;
            end
            default: begin
               nx = 2 * half - 1 - y;
               ny = half - 1 - x;
            end
         endcase
         x = nx;
         y = ny;
      end
      return {x, y};
   endfunction

   // Integer square root, rounded down, one result bit per pass.
   function automatic logic [63:0] root_floor(input logic [63:0] radicand);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest  = radicand;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Expected coordinates and rounded distance for one query.
   function automatic placement_type predict_placement(input query_type query);
      int unsigned levels;
      logic [127:0] point_a;
      logic [127:0] point_b;
      logic [63:0]  dx;
      logic [63:0]  dy;
      logic [63:0]  square;
      logic [63:0]  scaled;
      logic [63:0]  root;
      logic [63:0]  rounded;
      placement_type answer;
      levels = (query.level > CURVE_MAX_LEVEL) ? CURVE_MAX_LEVEL : query.level;
      point_a = curve_point(levels, query.block_a - 1'b1);
      point_b = curve_point(levels, query.block_b - 1'b1);
      dx = (point_a[127:64] > point_b[127:64]) ? point_a[127:64] - point_b[127:64]
                                               : point_b[127:64] - point_a[127:64];
      dy = (point_a[63:0] > point_b[63:0]) ? point_a[63:0] - point_b[63:0]
                                           : point_b[63:0] - point_a[63:0];
      square = dx * dx + dy * dy;
      if (square >= (64'd1 << D2_SAT_BIT)) begin
         rounded = {DIST_W{1'b1}};
      end else begin
         scaled  = SCALE_FACTOR * square;
         root    = root_floor(scaled);
         rounded = root + ((scaled > root * root + root) ? 64'd1 : 64'd0);
         if (rounded > {DIST_W{1'b1}}) rounded = {DIST_W{1'b1}};
      end
      answer.a_x      = point_a[64 +: COORD_OUT_W];
      answer.a_y      = point_a[0 +: COORD_OUT_W];
      answer.b_x      = point_b[64 +: COORD_OUT_W];
      answer.b_y      = point_b[0 +: COORD_OUT_W];
      answer.distance = rounded[DIST_W-1:0];
      return answer;
   endfunction

   // Queue a query from two zero-based curve indexes.
   task automatic add_query(input int unsigned level, input logic [63:0] index_a,
                            input logic [63:0] index_b);
      query_type query;
      query.level   = level[LEVEL_W-1:0];
      query.block_a = index_a[IDX_W-1:0] + 1'b1;
      query.block_b = index_b[IDX_W-1:0] + 1'b1;
      pending_queries.push_back(query);
   endtask

   // Directed corners, then random queries, then the end of run check.
   initial begin
      int unsigned level;
      logic [63:0] span;
      logic [63:0] index_a;
      logic [63:0] index_b;
      int unsigned pick;

      // Level zero, where every point is the origin.
      add_query(0, 0, 4);
      // Every quadrant of the smallest curve, then two queries on the next level.
      add_query(1, 0, 1);
      add_query(1, 2, 3);
      add_query(1, 0, 3);
      add_query(1, 1, 2);
      add_query(2, 0, 15);
      add_query(2, 5, 10);
      // The largest curve at its ends and its middle.
      add_query(16, 0, 64'hFFFF_FFFF);
      add_query(16, 0, 64'h8000_0000);
      add_query(16, 64'h5555_5555, 64'hAAAA_AAAA);
      add_query(16, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
      // Block number zero wraps to the largest index.
      add_query(16, 64'h1_FFFF_FFFF, 0);
      add_query(3, 63, 64'h1_FFFF_FFFF);
      // Block numbers past the end of the curve.
      add_query(16, 64'h1_0000_0000, 64'h1_FFFF_FFFE);
      add_query(3, 64, 100);
      add_query(5, 64'h400, 64'h3FF);
      // Levels beyond the largest saturate.
      add_query(17, 0, 64'hFFFF_FFFF);
      add_query(31, 12344, 64'h1_FFFF_FFFE);
      add_query(24, 64'hAAAA_AAAA, 64'h1_5555_5555);
      odd_queries = 9;

      // Random queries: mostly valid indexes, some near each other, the rest
      // anything the fields can carry.
      for (int n = 0; n < RANDOM_QUERIES; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            level   = $urandom_range(1, CURVE_MAX_LEVEL);
            span    = 64'd1 << (2 * level);
            index_a = {$urandom(), $urandom()} % span;
            if (pick < 25) begin
               index_b = (index_a + $urandom_range(0, 24)) % span;
            end else begin
               index_b = {$urandom(), $urandom()} % span;
            end
         end else begin
            level   = $urandom_range(0, 31);
            index_a = {$urandom(), $urandom()};
            index_b = {$urandom(), $urandom()};
            if (pick < 90) begin
               index_b = 64'h1_FFFF_FFFF;
            end else if (pick < 95 && level <= CURVE_MAX_LEVEL) begin
               index_b = (64'd1 << (2 * level)) + $urandom_range(0, 3);
            end
            odd_queries++;
         end
         add_query(level, index_a, index_b);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Let the last query go in, then every answer come out.
      while (pending_queries.size() != 0 || req_valid) @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d queries, %0d with out-of-range levels or blocks; %0d answers",
               queries_sent, odd_queries, answers_checked);
      $display("checked, largest distance %0d, %0d mismatches.",
               widest_distance, mismatch_count);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Request driver: offers queued queries, idles in random bursts and once
   // pauses until the unit has answered everything.
   always @(posedge clock) begin : query_driver
      query_type next_query;
      placement_type answer;
      static int send_gap = 0;
      static bit draining = 1'b0;
      static bit drain_done = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            answer = predict_placement({req_level, req_block_a, req_block_b});
            awaited_answers.push_back(answer);
            if (answer.distance > widest_distance) widest_distance <= answer.distance;
            queries_sent <= queries_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (draining && awaited_answers.size() == 0) begin
               draining = 1'b0;
               drain_done = 1'b1;
            end
            if (!drain_done && !draining && queries_sent >= DRAIN_AT) draining = 1'b1;
            if (draining || send_gap > 0 || pending_queries.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_valid <= 1'b0;
            end else begin
               next_query = pending_queries.pop_front();
               req_valid   <= 1'b1;
               req_level   <= next_query.level;
               req_block_a <= next_query.block_a;
               req_block_b <= next_query.block_b;
               if (pending_queries.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 9);
               end
            end
         end
      end
   end

   // Long response hold-off once, so the unit backs up into its input.
   always @(posedge clock) begin : long_hold
      static bit hold_done = 1'b0;
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && queries_sent >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor: checks each transaction against the oldest expected
   // answer and stalls in random bursts.
   always @(posedge clock) begin : answer_monitor
      placement_type seen;
      placement_type wanted;
      static int stall_left = 0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_a_x, rsp_a_y, rsp_b_x, rsp_b_y, rsp_distance};
            if (awaited_answers.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("Unexpected response: a=(%0d,%0d) b=(%0d,%0d) distance %0d",
                           seen.a_x, seen.a_y, seen.b_x, seen.b_y, seen.distance);
               end
               mismatch_count++;
            end else begin
               wanted = awaited_answers.pop_front();
               if (seen.a_x !== wanted.a_x || seen.a_y !== wanted.a_y ||
                   seen.b_x !== wanted.b_x || seen.b_y !== wanted.b_y ||
                   seen.distance !== wanted.distance) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display("Mismatch on answer %0d: expected a=(%0d,%0d) b=(%0d,%0d) d=%0d,",
                              answers_checked, wanted.a_x, wanted.a_y, wanted.b_x,
                              wanted.b_y, wanted.distance);
                     $display("   got a=(%0d,%0d) b=(%0d,%0d) d=%0d", seen.a_x, seen.a_y,
                              seen.b_x, seen.b_y, seen.distance);
                  end
                  mismatch_count++;
               end
            end
            answers_checked++;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else if (pending_queries.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         rsp_stall <= (hold_left != 0) || (stall_left != 0);
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d answers outstanding.",
                  cycle_count, awaited_answers.size());
         $display("testbench: errors");
         $finish;
      end
   end

endmodule

/* filelist.f */
design/hbd_pkg.sv
design/hbd_lane.sv
design/hbd_isqrt.sv
design/hilbert_block_distance_unit.sv
tb/testbench.sv
